// File: sv/rij_pkg.sv
// shared types, constants and helpers of the raster interval pair join unit
package rij_pkg;

	localparam int MAX_INTERVALS = 256;
	localparam int MAX_CELLS     = 21;
	localparam int CODE_BITS     = 3;

	localparam int IDX_W   = $clog2(MAX_INTERVALS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int CODE_W  = MAX_CELLS * CODE_BITS;
	localparam int MASK_W  = CODE_W + 1;
	localparam int SKIP_W  = $clog2(MAX_CELLS + 1);
	localparam int SH_W    = $clog2(CODE_W) + 1;
	localparam int CELL_W  = 32;
	localparam int ID_W    = 32;
	localparam int VERD_W  = 2;

	localparam logic [VERD_W-1:0] VERDICT_DISJOINT    = 2'd0;
	localparam logic [VERD_W-1:0] VERDICT_HIT         = 2'd1;
	localparam logic [VERD_W-1:0] VERDICT_INDECISIVE  = 2'd2;

	typedef struct packed {
		logic [CELL_W-1:0] start;
		logic [CELL_W-1:0] stop;
		logic [CODE_W-1:0] codes;
	} rij_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             complete;
		logic             full;
		logic [ID_W-1:0]  ident;
	} rij_list_stat_t;

	typedef struct packed {
		logic overlap;
		logic adv_left;
		logic hit;
	} rij_step_t;

	// code mask covering the first n cells
	function automatic logic [CODE_W-1:0] cells_mask(input logic [SKIP_W-1:0] n);
		logic [MASK_W-1:0] bit_q;
		bit_q = MASK_W'(1) << (n * CODE_BITS);
		return CODE_W'(bit_q - MASK_W'(1));
	endfunction

endpackage

// File: sv/rij_if.sv
// valid/ready channel interfaces for interval beats and verdict beats
interface rij_in_if import rij_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              side;
	logic [ID_W-1:0]   object_id;
	logic [CELL_W-1:0] interval_start;
	logic [CELL_W-1:0] interval_end;
	logic [CODE_W-1:0] cell_codes;
	logic              last_interval;

	modport source (output valid, side, object_id, interval_start, interval_end,
		cell_codes, last_interval, input ready);
	modport sink (input valid, side, object_id, interval_start, interval_end,
		cell_codes, last_interval, output ready);
endinterface

interface rij_out_if import rij_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VERD_W-1:0] verdict;
	logic [ID_W-1:0]   left_object;
	logic [ID_W-1:0]   right_object;
	logic              list_overflow;

	modport source (output valid, verdict, left_object, right_object, list_overflow,
		input ready);
	modport sink (input valid, verdict, left_object, right_object, list_overflow,
		output ready);
endinterface

// File: sv/rij_list_store.sv
// interval memory of one side with its fill count, completion and object id
module rij_list_store import rij_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             clear,
	input  logic [ID_W-1:0]  id,
	input  rij_entry_t       wr_entry,
	input  logic             last,
	input  logic [IDX_W-1:0] rd_addr,
	output rij_entry_t       rd_entry,
	output rij_list_stat_t   stat
);

	rij_entry_t       mem [MAX_INTERVALS];
	logic [CNT_W-1:0] count_q;
	logic             complete_q;
	logic [ID_W-1:0]  ident_q;
	logic             full;
	logic             take;

	assign full = (count_q == CNT_W'(MAX_INTERVALS));
	assign take = load && !complete_q;

	always_ff @(posedge clk) begin
		if (take && !full) begin
			mem[count_q[IDX_W-1:0]] <= wr_entry;
		end
		rd_entry <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			complete_q <= 1'b0;
			ident_q    <= '0;
		end else if (clear) begin
			count_q    <= '0;
			complete_q <= 1'b0;
			ident_q    <= '0;
		end else if (take) begin
			ident_q <= id;
			if (!full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (last) begin
				complete_q <= 1'b1;
			end
		end
	end

	assign stat.count    = count_q;
	assign stat.complete = complete_q;
	assign stat.full     = full;
	assign stat.ident    = ident_q;

endmodule

// File: sv/rij_overlap_unit.sv
// two-step interval overlap unit: bounds compare, then aligned code AND
module rij_overlap_unit import rij_pkg::*; (
	input  logic       clk,
	input  logic       cmp_en,
	input  rij_entry_t left_ent,
	input  rij_entry_t right_ent,
	output rij_step_t  step
);

	logic [CELL_W-1:0] s_cell;
	logic [CELL_W-1:0] e_cell;
	logic [CELL_W-1:0] dl;
	logic [CELL_W-1:0] dr;
	logic [CELL_W-1:0] dn;
	logic              ov;

	logic              ov_q;
	logic              adv_left_q;
	logic [SKIP_W-1:0] skip_l_q;
	logic [SKIP_W-1:0] skip_r_q;
	logic              kill_l_q;
	logic              kill_r_q;
	logic [SKIP_W-1:0] ncell_q;

	logic [CODE_W-1:0] a_codes;
	logic [CODE_W-1:0] b_codes;
	logic [CODE_W-1:0] mask;

	always_comb begin
		ov = (left_ent.start <= left_ent.stop) && (right_ent.start <= right_ent.stop) &&
			!((left_ent.stop < right_ent.start) || (right_ent.stop < left_ent.start));
		s_cell = (left_ent.start > right_ent.start) ? left_ent.start : right_ent.start;
		e_cell = (left_ent.stop < right_ent.stop) ? left_ent.stop : right_ent.stop;
		dl = s_cell - left_ent.start;
		dr = s_cell - right_ent.start;
		dn = e_cell - s_cell;
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			ov_q       <= ov;
			adv_left_q <= (left_ent.stop <= right_ent.stop);
			kill_l_q   <= (dl >= CELL_W'(MAX_CELLS));
			kill_r_q   <= (dr >= CELL_W'(MAX_CELLS));
			skip_l_q   <= dl[SKIP_W-1:0];
			skip_r_q   <= dr[SKIP_W-1:0];
			ncell_q    <= (dn >= CELL_W'(MAX_CELLS - 1)) ? SKIP_W'(MAX_CELLS) :
				dn[SKIP_W-1:0] + SKIP_W'(1);
		end
	end

	// entries stay at the same read address through this step
	always_comb begin
		mask    = cells_mask(ncell_q);
		a_codes = kill_l_q ? '0 :
			(left_ent.codes >> (SH_W'(skip_l_q) * SH_W'(CODE_BITS)));
		b_codes = kill_r_q ? '0 :
			(right_ent.codes >> (SH_W'(skip_r_q) * SH_W'(CODE_BITS)));
	end

	assign step.overlap  = ov_q;
	assign step.adv_left = adv_left_q;
	assign step.hit      = ov_q && (|(a_codes & b_codes & mask));

endmodule

// File: sv/raster_interval_pair_join_unit.sv
// top level: loads two interval lists, merge-walks them and reports one verdict per pair
// Interval beats are taken while in_ch.ready is high. The beat that completes the second
// list starts the merge walk, during which in_ch.ready is low: every walk step passes
// through ST_READ, ST_CMP and ST_AND (registered memory read, bounds compare, aligned
// code AND in the shared overlap unit), one step per interval pair visited, at most
// left_count + right_count - 1 steps, then a final end check in ST_READ; a true hit ends
// the walk at once. The verdict beat is then held on out_ch until taken, and the next
// interval is taken in the cycle after. No clearing pass is needed after reset.
module raster_interval_pair_join_unit import rij_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rij_in_if.sink    in_ch,
	rij_out_if.source out_ch
);

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_READ = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_AND  = 5'b01000,
		ST_OUT  = 5'b10000
	} rij_state_t;

	rij_state_t        state_q;
	logic [CNT_W-1:0]  li_q;
	logic [CNT_W-1:0]  rj_q;
	logic              overlapped_q;
	logic              dropped_q;
	logic [VERD_W-1:0] verdict_q;

	logic           in_acc;
	logic           out_acc;
	logic           load_l;
	logic           load_r;
	logic           l_done_nxt;
	logic           r_done_nxt;
	logic           drop;
	rij_entry_t     wr_entry;
	rij_entry_t     l_ent;
	rij_entry_t     r_ent;
	rij_list_stat_t l_stat;
	rij_list_stat_t r_stat;
	rij_step_t      step;

	assign in_ch.ready = (state_q == ST_LOAD);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_acc     = out_ch.valid && out_ch.ready;
	assign load_l      = in_acc && !in_ch.side;
	assign load_r      = in_acc && in_ch.side;
	assign l_done_nxt  = l_stat.complete || (load_l && in_ch.last_interval);
	assign r_done_nxt  = r_stat.complete || (load_r && in_ch.last_interval);
	assign drop        = (load_l && !l_stat.complete && l_stat.full) ||
		(load_r && !r_stat.complete && r_stat.full);

	assign wr_entry.start = in_ch.interval_start;
	assign wr_entry.stop  = in_ch.interval_end;
	assign wr_entry.codes = in_ch.cell_codes;

	rij_list_store u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_l),
		.clear    (out_acc),
		.id       (in_ch.object_id),
		.wr_entry (wr_entry),
		.last     (in_ch.last_interval),
		.rd_addr  (li_q[IDX_W-1:0]),
		.rd_entry (l_ent),
		.stat     (l_stat)
	);

	rij_list_store u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_r),
		.clear    (out_acc),
		.id       (in_ch.object_id),
		.wr_entry (wr_entry),
		.last     (in_ch.last_interval),
		.rd_addr  (rj_q[IDX_W-1:0]),
		.rd_entry (r_ent),
		.stat     (r_stat)
	);

	rij_overlap_unit u_ovl (
		.clk       (clk),
		.cmp_en    (state_q == ST_CMP),
		.left_ent  (l_ent),
		.right_ent (r_ent),
		.step      (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			li_q         <= '0;
			rj_q         <= '0;
			overlapped_q <= 1'b0;
			dropped_q    <= 1'b0;
			verdict_q    <= VERDICT_DISJOINT;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (drop) begin
						dropped_q <= 1'b1;
					end
					if (in_acc && l_done_nxt && r_done_nxt) begin
						li_q         <= '0;
						rj_q         <= '0;
						overlapped_q <= 1'b0;
						state_q      <= ST_READ;
					end
				end
				ST_READ: begin
					if ((li_q >= l_stat.count) || (rj_q >= r_stat.count)) begin
						verdict_q <= overlapped_q ? VERDICT_INDECISIVE : VERDICT_DISJOINT;
						state_q   <= ST_OUT;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_AND;
				end
				ST_AND: begin
					if (step.hit) begin
						verdict_q <= VERDICT_HIT;
						state_q   <= ST_OUT;
					end else begin
						overlapped_q <= overlapped_q || step.overlap;
						if (step.adv_left) begin
							li_q <= li_q + CNT_W'(1);
						end else begin
							rj_q <= rj_q + CNT_W'(1);
						end
						state_q <= ST_READ;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						dropped_q <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign out_ch.valid         = (state_q == ST_OUT);
	assign out_ch.verdict       = verdict_q;
	assign out_ch.left_object   = l_stat.ident;
	assign out_ch.right_object  = r_stat.ident;
	assign out_ch.list_overflow = dropped_q;

endmodule

// File: sv/rij_checker.sv
// port-level checks of the join unit and their binding to the top level
module rij_checker import rij_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [VERD_W-1:0] verdict
);

	// no interval is taken while a verdict is pending
	a_no_load_during_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("interval beat possible while verdict pending");

	// a taken verdict frees the input side at once
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("input not ready after verdict beat");

	// verdict code is one of the three defined values
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == VERDICT_DISJOINT || verdict == VERDICT_HIT ||
			verdict == VERDICT_INDECISIVE))
		else $error("undefined verdict code");

	// a stalled verdict beat holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(verdict)))
		else $error("verdict beat dropped or changed while stalled");

endmodule

bind raster_interval_pair_join_unit rij_checker u_rij_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.verdict   (out_ch.verdict)
);
